@@ design/sld_pkg.sv @@
// sld_pkg: shared types and constants of the sync/length/checksum deframer
// holds parser phase encoding, field kind and error codes, and the result word
// no dependencies
`default_nettype none

package sld_pkg;

  // frame layout constants
  localparam int unsigned SERIAL_BYTES = 8;
  localparam int unsigned PACKET_MAX   = 256;

  localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND = 8'h55;
  localparam logic [15:0] LENGTH_MIN  = 16'd5;

  // configuration register reset values
  localparam logic [7:0]  TIMEOUT_RESET = 8'd5;
  localparam logic [15:0] LIMIT_RESET   = 16'(PACKET_MAX - 8);

  // configuration register indexes
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_LIMIT   = 1'b1;

  // field kinds reported with each word
  localparam logic [3:0] KIND_NONE     = 4'd0;
  localparam logic [3:0] KIND_SYNC     = 4'd1;
  localparam logic [3:0] KIND_TYPE     = 4'd2;
  localparam logic [3:0] KIND_SERIAL   = 4'd3;
  localparam logic [3:0] KIND_LENGTH   = 4'd4;
  localparam logic [3:0] KIND_VERSION  = 4'd5;
  localparam logic [3:0] KIND_SEQUENCE = 4'd6;
  localparam logic [3:0] KIND_COMMAND  = 4'd7;
  localparam logic [3:0] KIND_PAYLOAD  = 4'd8;
  localparam logic [3:0] KIND_CHECKSUM = 4'd9;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SYNC2     = 3'd1;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd2;
  localparam logic [2:0] ERR_TOO_SMALL = 3'd3;
  localparam logic [2:0] ERR_CHECKSUM  = 3'd4;
  localparam logic [2:0] ERR_TIMEOUT   = 3'd5;

  // parser phases, one-hot
  typedef enum logic [9:0] {
    PH_HUNT    = 10'b00_0000_0001,
    PH_SYNC2   = 10'b00_0000_0010,
    PH_TYPE    = 10'b00_0000_0100,
    PH_SERIAL  = 10'b00_0000_1000,
    PH_LEN     = 10'b00_0001_0000,
    PH_VER     = 10'b00_0010_0000,
    PH_SEQ     = 10'b00_0100_0000,
    PH_CMD     = 10'b00_1000_0000,
    PH_PAYLOAD = 10'b01_0000_0000,
    PH_CHK     = 10'b10_0000_0000
  } phase_t;

  // one classified word
  typedef struct packed {
    logic [3:0] field_kind;
    logic [7:0] out_byte;
    logic       frame_start;
    logic       frame_end;
    logic       frame_ok;
    logic [2:0] error_code;
  } result_t;

  // configuration as seen by the parser
  typedef struct packed {
    logic [7:0]  timeout_seconds;
    logic [15:0] length_limit;
  } cfg_t;

endpackage

`default_nettype wire

@@ design/sync_length_checksum_deframer_top.sv @@
// sync_length_checksum_deframer_top: top level of the frame deframer
// input register, parser, result register and configuration registers
// depends on sld_pkg and sld_parser
//
// Usage:
//   in_*  : one word per accepted transfer (in_valid high, in_stall low).
//           in_mode 0 carries a received byte in in_rx_byte, in_mode 1 is a
//           one-second tick. Every word gives exactly one result word.
//   out_* : the classified word: field kind, echoed byte, frame start/end,
//           checksum good flag and error code. Accepted when out_valid is
//           high and out_stall low.
//   cfg_* : register writes, always ready. Index 0 is timeout_seconds
//           (low 8 bits of cfg_data), index 1 is length_limit.
// out_valid rises once an accepted word has passed the input register and
// the parser step into the result register; throughput is one word per
// cycle while out_stall is low, set by the combinational parser step between
// the input and result registers. When out_stall holds the result register,
// the input register still takes one more word, then in_stall rises.
// Reset puts the parser in sync hunt, empties both registers and loads
// timeout_seconds = 5 and length_limit = 248.
`default_nettype none

module sync_length_checksum_deframer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_rx_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_field_kind,
  output logic [7:0]       out_out_byte,
  output logic             out_frame_start,
  output logic             out_frame_end,
  output logic             out_frame_ok,
  output logic [2:0]       out_error_code,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_mode_r;
  logic [7:0]       s1_byte_r;
  logic             out_valid_r, out_valid_nxt;
  sld_pkg::result_t out_res_r;
  sld_pkg::result_t res;
  sld_pkg::cfg_t    cfg_r;

  logic out_free;
  logic advance;
  logic accept;

  // handshake control
  assign out_free      = !out_valid_r || !out_stall;
  assign advance       = s1_valid_r && out_free;
  assign in_stall      = s1_valid_r && !out_free;
  assign accept        = in_valid && !in_stall;
  assign s1_valid_nxt  = accept || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r <= in_mode;
      s1_byte_r <= in_rx_byte;
    end
  end

  // parser step
  sld_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .mode    (s1_mode_r),
    .rx_byte (s1_byte_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_seconds <= sld_pkg::TIMEOUT_RESET;
      cfg_r.length_limit    <= sld_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sld_pkg::CFG_TIMEOUT: cfg_r.timeout_seconds <= cfg_data[7:0];
        sld_pkg::CFG_LIMIT:   cfg_r.length_limit    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // output ports
  assign out_valid       = out_valid_r;
  assign out_field_kind  = out_res_r.field_kind;
  assign out_out_byte    = out_res_r.out_byte;
  assign out_frame_start = out_res_r.frame_start;
  assign out_frame_end   = out_res_r.frame_end;
  assign out_frame_ok    = out_res_r.frame_ok;
  assign out_error_code  = out_res_r.error_code;

endmodule

`default_nettype wire

@@ design/sld_parser.sv @@
// sld_parser: frame parser state and per-word classification logic
// one word is classified per step; result is combinational from state and word
// depends on sld_pkg
`default_nettype none

module sld_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic            mode,
  input  wire logic [7:0]      rx_byte,
  input  wire sld_pkg::cfg_t   cfg,
  output sld_pkg::result_t     res
);

  sld_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] field_count_r, field_count_nxt;
  logic [7:0]  length_low_r, length_low_nxt;
  logic [15:0] frame_length_r, frame_length_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [7:0]  elapsed_r, elapsed_nxt;

  logic [15:0] count_dec;
  logic [15:0] length_word;
  logic [7:0]  sum_add;

  assign count_dec   = field_count_r - 16'd1;
  assign length_word = {rx_byte, length_low_r};
  assign sum_add     = running_sum_r + rx_byte;

  // next state and result for the word at hand
  always_comb begin
    phase_nxt        = phase_r;
    field_count_nxt  = field_count_r;
    length_low_nxt   = length_low_r;
    frame_length_nxt = frame_length_r;
    running_sum_nxt  = running_sum_r;
    elapsed_nxt      = elapsed_r;
    res              = '0;

    if (mode) begin
      // second tick: timeout check inside a frame
      if (phase_r != sld_pkg::PH_HUNT) begin
        if (elapsed_r >= cfg.timeout_seconds) begin
          res.error_code = sld_pkg::ERR_TIMEOUT;
          phase_nxt      = sld_pkg::PH_HUNT;
        end else begin
          elapsed_nxt = elapsed_r + 8'd1;
        end
      end
    end else begin
      res.out_byte = rx_byte;
      case (phase_r)
        sld_pkg::PH_SYNC2: begin
          if (rx_byte == sld_pkg::SYNC_SECOND) begin
            res.field_kind = sld_pkg::KIND_SYNC;
            phase_nxt      = sld_pkg::PH_TYPE;
          end else begin
            res.error_code = sld_pkg::ERR_SYNC2;
            phase_nxt      = sld_pkg::PH_HUNT;
          end
        end
        sld_pkg::PH_TYPE: begin
          res.field_kind  = sld_pkg::KIND_TYPE;
          field_count_nxt = 16'(sld_pkg::SERIAL_BYTES);
          phase_nxt       = sld_pkg::PH_SERIAL;
        end
        sld_pkg::PH_SERIAL: begin
          res.field_kind = sld_pkg::KIND_SERIAL;
          if (count_dec == 16'd0) begin
            field_count_nxt = 16'd2;
            phase_nxt       = sld_pkg::PH_LEN;
          end else begin
            field_count_nxt = count_dec;
          end
        end
        sld_pkg::PH_LEN: begin
          res.field_kind = sld_pkg::KIND_LENGTH;
          if (field_count_r == 16'd2) begin
            length_low_nxt  = rx_byte;
            field_count_nxt = 16'd1;
          end else begin
            frame_length_nxt = length_word;
            field_count_nxt  = 16'd0;
            if (length_word >= cfg.length_limit) begin
              res.error_code = sld_pkg::ERR_TOO_LARGE;
              phase_nxt      = sld_pkg::PH_HUNT;
            end else begin
              running_sum_nxt = 8'd0;
              phase_nxt       = sld_pkg::PH_VER;
            end
          end
        end
        sld_pkg::PH_VER: begin
          res.field_kind  = sld_pkg::KIND_VERSION;
          running_sum_nxt = sum_add;
          field_count_nxt = 16'd2;
          phase_nxt       = sld_pkg::PH_SEQ;
        end
        sld_pkg::PH_SEQ: begin
          res.field_kind  = sld_pkg::KIND_SEQUENCE;
          running_sum_nxt = sum_add;
          field_count_nxt = count_dec;
          if (count_dec == 16'd0) begin
            phase_nxt = sld_pkg::PH_CMD;
          end
        end
        sld_pkg::PH_CMD: begin
          res.field_kind  = sld_pkg::KIND_COMMAND;
          running_sum_nxt = sum_add;
          if (frame_length_r < sld_pkg::LENGTH_MIN) begin
            res.error_code = sld_pkg::ERR_TOO_SMALL;
            phase_nxt      = sld_pkg::PH_HUNT;
          end else begin
            field_count_nxt = frame_length_r - sld_pkg::LENGTH_MIN;
            // empty payload goes straight to the checksum
            if (frame_length_r != sld_pkg::LENGTH_MIN) begin
              phase_nxt = sld_pkg::PH_PAYLOAD;
            end else begin
              phase_nxt = sld_pkg::PH_CHK;
            end
          end
        end
        sld_pkg::PH_PAYLOAD: begin
          res.field_kind  = sld_pkg::KIND_PAYLOAD;
          running_sum_nxt = sum_add;
          field_count_nxt = count_dec;
          if (count_dec == 16'd0) begin
            phase_nxt = sld_pkg::PH_CHK;
          end
        end
        sld_pkg::PH_CHK: begin
          res.field_kind = sld_pkg::KIND_CHECKSUM;
          res.frame_end  = 1'b1;
          if (rx_byte == running_sum_r) begin
            res.frame_ok = 1'b1;
          end else begin
            res.error_code = sld_pkg::ERR_CHECKSUM;
          end
          phase_nxt = sld_pkg::PH_HUNT;
        end
        default: begin
          // hunting the first sync byte
          if (rx_byte == sld_pkg::SYNC_FIRST) begin
            res.field_kind  = sld_pkg::KIND_SYNC;
            res.frame_start = 1'b1;
            elapsed_nxt     = 8'd0;
            phase_nxt       = sld_pkg::PH_SYNC2;
          end else begin
            phase_nxt = sld_pkg::PH_HUNT;
          end
        end
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= sld_pkg::PH_HUNT;
      field_count_r  <= 16'd0;
      length_low_r   <= 8'd0;
      frame_length_r <= 16'd0;
      running_sum_r  <= 8'd0;
      elapsed_r      <= 8'd0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      field_count_r  <= field_count_nxt;
      length_low_r   <= length_low_nxt;
      frame_length_r <= frame_length_nxt;
      running_sum_r  <= running_sum_nxt;
      elapsed_r      <= elapsed_nxt;
    end
  end

endmodule

`default_nettype wire

@@ bench/frame_word_checker.sv @@
// frame_word_checker: watches the deframer's word, result and register channels
// predicts each classified word and compares it with what comes out
// depends on sld_pkg
`default_nettype none

module frame_word_checker
  import sld_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [3:0]  out_field_kind,
  input  wire logic [7:0]  out_out_byte,
  input  wire logic        out_frame_start,
  input  wire logic        out_frame_end,
  input  wire logic        out_frame_ok,
  input  wire logic [2:0]  out_error_code,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               mismatch_count,
  output int               words_waiting,
  output int               words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [7:0]  cur_timeout;
  logic [15:0] cur_limit;

  // parser state
  phase_t      parse_phase;
  logic [15:0] bytes_left;
  logic [7:0]  len_low;
  logic [15:0] frame_len;
  logic [7:0]  sum_acc;
  logic [7:0]  secs_elapsed;

  result_t expected_q[$];
  int      errors;
  int      checked;

  // classify one word and advance the parser state
  function automatic result_t classify_word(input logic tick, input logic [7:0] b);
    result_t r;
    r = '0;
    if (tick) begin
      // ticks only count inside a frame
      if (parse_phase != PH_HUNT) begin
        if (secs_elapsed >= cur_timeout) begin
          r.error_code = ERR_TIMEOUT;
          parse_phase = PH_HUNT;
        end else begin
          secs_elapsed = secs_elapsed + 8'd1;
        end
      end
    end else begin
      r.out_byte = b;
      case (parse_phase)
        PH_SYNC2: begin
          // a bad second sync byte is not retried as a first sync
          if (b == SYNC_SECOND) begin
            r.field_kind = KIND_SYNC;
            parse_phase = PH_TYPE;
          end else begin
            r.error_code = ERR_SYNC2;
            parse_phase = PH_HUNT;
          end
        end
        PH_TYPE: begin
          r.field_kind = KIND_TYPE;
          bytes_left = 16'(SERIAL_BYTES);
          parse_phase = PH_SERIAL;
        end
        PH_SERIAL: begin
          r.field_kind = KIND_SERIAL;
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 16'd0) begin
            parse_phase = PH_LEN;
            bytes_left = 16'd2;
          end
        end
        PH_LEN: begin
          // little-endian length, limit checked on the full word once the high byte arrives
          r.field_kind = KIND_LENGTH;
          if (bytes_left == 16'd2) begin
            len_low = b;
            bytes_left = 16'd1;
          end else begin
            frame_len = {b, len_low};
            bytes_left = 16'd0;
            if (frame_len >= cur_limit) begin
              r.error_code = ERR_TOO_LARGE;
              parse_phase = PH_HUNT;
            end else begin
              sum_acc = 8'd0;
              parse_phase = PH_VER;
            end
          end
        end
        PH_VER: begin
          r.field_kind = KIND_VERSION;
          sum_acc = sum_acc + b;
          bytes_left = 16'd2;
          parse_phase = PH_SEQ;
        end
        PH_SEQ: begin
          r.field_kind = KIND_SEQUENCE;
          sum_acc = sum_acc + b;
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 16'd0) parse_phase = PH_CMD;
        end
        PH_CMD: begin
          // short lengths fail here; length of exactly the minimum skips the payload
          r.field_kind = KIND_COMMAND;
          sum_acc = sum_acc + b;
          if (frame_len < LENGTH_MIN) begin
            r.error_code = ERR_TOO_SMALL;
            parse_phase = PH_HUNT;
          end else begin
            bytes_left = frame_len - LENGTH_MIN;
            parse_phase = (bytes_left != 16'd0) ? PH_PAYLOAD : PH_CHK;
          end
        end
        PH_PAYLOAD: begin
          r.field_kind = KIND_PAYLOAD;
          sum_acc = sum_acc + b;
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 16'd0) parse_phase = PH_CHK;
        end
        PH_CHK: begin
          r.field_kind = KIND_CHECKSUM;
          r.frame_end = 1'b1;
          if (b == sum_acc) r.frame_ok = 1'b1;
          else r.error_code = ERR_CHECKSUM;
          parse_phase = PH_HUNT;
        end
        default: begin
          // hunting for the first sync byte
          if (b == SYNC_FIRST) begin
            r.field_kind = KIND_SYNC;
            r.frame_start = 1'b1;
            secs_elapsed = 8'd0;
            parse_phase = PH_SYNC2;
          end else begin
            parse_phase = PH_HUNT;
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic int field_differs(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
    if (want !== got) begin
      $display("@%0t ns %s: expected 0x%h, actual 0x%h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // track register writes, predict accepted words, compare accepted results
  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (!rst_n) begin
      cur_timeout = TIMEOUT_RESET;
      cur_limit = LIMIT_RESET;
      parse_phase = PH_HUNT;
      bytes_left = '0;
      len_low = '0;
      frame_len = '0;
      sum_acc = '0;
      secs_elapsed = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TIMEOUT) cur_timeout = cfg_data[7:0];
        else cur_limit = cfg_data;
      end
      if (out_valid && !out_stall) begin
        seen = {out_field_kind, out_out_byte, out_frame_start, out_frame_end,
                out_frame_ok, out_error_code};
        checked++;
        if (expected_q.size() == 0) begin
          $display("@%0t ns result word 0x%h with nothing expected", $time, seen);
          errors++;
        end else begin
          want = expected_q.pop_front();
          errors += field_differs("field_kind", 8'(want.field_kind), 8'(seen.field_kind));
          errors += field_differs("out_byte", want.out_byte, seen.out_byte);
          errors += field_differs("frame_start", 8'(want.frame_start), 8'(seen.frame_start));
          errors += field_differs("frame_end", 8'(want.frame_end), 8'(seen.frame_end));
          errors += field_differs("frame_ok", 8'(want.frame_ok), 8'(seen.frame_ok));
          errors += field_differs("error_code", 8'(want.error_code), 8'(seen.error_code));
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(classify_word(in_mode, in_rx_byte));
    end
    mismatch_count <= errors;
    words_waiting <= expected_q.size();
    words_checked <= checked;
  end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// testbench: drives frames, ticks and register writes into the deframer
// instantiates sync_length_checksum_deframer_top and frame_word_checker, gives the verdict
// depends on sld_pkg
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sld_pkg::*;

  typedef enum int {
    FR_GOOD, FR_BAD_SUM, FR_BAD_SYNC, FR_TOO_LARGE, FR_TOO_SMALL, FR_CUT
  } frame_variant_t;

  localparam int N_SETTINGS = 7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_field_kind;
  logic [7:0]  out_out_byte;
  logic        out_frame_start;
  logic        out_frame_end;
  logic        out_frame_ok;
  logic [2:0]  out_error_code;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int words_waiting;
  int words_checked;

  // register settings per phase; the first and last match the reset values
  int tmo_set[N_SETTINGS]   = '{5, 1, 255, 2, 3, 128, 5};
  int lim_set[N_SETTINGS]   = '{248, 5, 65535, 64, 300, 6, 248};
  int quota_set[N_SETTINGS] = '{250, 200, 550, 250, 250, 150, 200};

  bit gaps_on;
  int hold_cycles;
  int tmo_now;
  int limit_now;
  int frame_words;
  int frames_sent;

  sync_length_checksum_deframer_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_field_kind  (out_field_kind),
    .out_out_byte    (out_out_byte),
    .out_frame_start (out_frame_start),
    .out_frame_end   (out_frame_end),
    .out_frame_ok    (out_frame_ok),
    .out_error_code  (out_error_code),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  frame_word_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_field_kind  (out_field_kind),
    .out_out_byte    (out_out_byte),
    .out_frame_start (out_frame_start),
    .out_frame_end   (out_frame_end),
    .out_frame_ok    (out_frame_ok),
    .out_error_code  (out_error_code),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (fail_count),
    .words_waiting   (words_waiting),
    .words_checked   (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #400_000;
    $display("Mismatches found");
    $finish;
  end

  // result side: random stalls, plus a long counted hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < 18);
      end
    end
  end

  // offer one word and wait until it is taken
  task automatic send_word(input logic tick, input logic [7:0] b);
    if (gaps_on && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= tick;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes follow on directly
  task automatic write_reg(input logic idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic logic [15:0] pick_length(input frame_variant_t v);
    int top_len;
    int room;
    case (v)
      FR_TOO_SMALL: return 16'($urandom_range(0, 4));
      FR_TOO_LARGE: begin
        room = 65535 - limit_now;
        if (room > 3) room = 3;
        if ($urandom_range(1)) return 16'($urandom_range(limit_now, 65535));
        return 16'(limit_now + $urandom_range(0, room));
      end
      default: begin
        // mostly short payloads, some empty, a few right under the limit
        top_len = limit_now - 1;
        if (top_len > 45) top_len = 45;
        if ($urandom_range(3) == 0) return LENGTH_MIN;
        if ($urandom_range(9) == 0 && limit_now <= 300) return 16'(limit_now - 1);
        return 16'($urandom_range(5, top_len));
      end
    endcase
  endfunction

  // build one frame and send it, with ticks sprinkled in at tick_pct percent
  task automatic send_frame(input frame_variant_t v, input logic [15:0] len,
                            input int tick_pct);
    logic [7:0] word_q[$];
    logic [7:0] sum;
    logic [7:0] b;
    int n_send;
    word_q.push_back(SYNC_FIRST);
    if (v == FR_BAD_SYNC) begin
      if ($urandom_range(2) == 0) begin
        b = SYNC_FIRST;
      end else begin
        do b = 8'($urandom); while (b == SYNC_SECOND);
      end
      word_q.push_back(b);
    end else begin
      word_q.push_back(SYNC_SECOND);
      // type byte and serial number
      repeat (1 + SERIAL_BYTES) word_q.push_back(8'($urandom));
      word_q.push_back(len[7:0]);
      word_q.push_back(len[15:8]);
      if (v != FR_TOO_LARGE) begin
        // version, two sequence bytes, command
        sum = 8'd0;
        repeat (4) begin
          b = 8'($urandom);
          sum += b;
          word_q.push_back(b);
        end
        if (v != FR_TOO_SMALL) begin
          repeat (int'(len) - 5) begin
            b = 8'($urandom);
            sum += b;
            word_q.push_back(b);
          end
          word_q.push_back((v == FR_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum);
        end
      end
    end
    n_send = word_q.size();
    if (v == FR_CUT) n_send = $urandom_range(2, word_q.size() - 1);
    for (int i = 0; i < n_send; i++) begin
      if (tick_pct > 0 && $urandom_range(99) < tick_pct) send_word(1'b1, 8'($urandom));
      send_word(1'b0, word_q[i]);
      frame_words++;
    end
    // a truncated frame is left to time out
    if (v == FR_CUT) repeat (tmo_now + 1) send_word(1'b1, 8'($urandom));
    frames_sent++;
  endtask

  task automatic random_frame();
    int pick;
    int tick_pct;
    frame_variant_t v;
    pick = $urandom_range(99);
    if (pick < 58) v = FR_GOOD;
    else if (pick < 68) v = FR_BAD_SUM;
    else if (pick < 75) v = FR_BAD_SYNC;
    else if (pick < 83) v = FR_TOO_LARGE;
    else if (pick < 90) v = FR_TOO_SMALL;
    else v = FR_CUT;
    // long timeouts would make truncated frames costly to recover from
    if (v == FR_CUT && tmo_now > 8) v = FR_BAD_SUM;
    // with the lowest limit no length reaches the payload
    if (limit_now <= LENGTH_MIN && (v == FR_GOOD || v == FR_BAD_SUM || v == FR_CUT))
      v = pick[0] ? FR_TOO_SMALL : FR_TOO_LARGE;
    tick_pct = ($urandom_range(99) < 30) ? $urandom_range(3, 15) : 0;
    // occasional line noise between frames
    if ($urandom_range(99) < 15)
      repeat ($urandom_range(1, 3)) send_word(1'($urandom_range(1)), 8'($urandom));
    send_frame(v, pick_length(v), tick_pct);
  endtask

  initial begin : stimulus
    int phase_end;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= 1'b0;
    in_rx_byte <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_TIMEOUT;
    cfg_data <= 16'h0000;
    gaps_on = 1'b1;
    hold_cycles = 0;
    tmo_now = TIMEOUT_RESET;
    limit_now = LIMIT_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: tick and odd bytes while hunting, a bad second sync that is
    // itself a first sync byte, a stray second sync, then an empty-payload frame
    send_word(1'b1, 8'hFF);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, SYNC_FIRST);
    send_word(1'b0, SYNC_FIRST);
    send_word(1'b0, SYNC_SECOND);
    send_frame(FR_GOOD, LENGTH_MIN, 0);

    // random frames under each register setting
    for (int s = 0; s < N_SETTINGS; s++) begin
      drain();
      write_reg(CFG_TIMEOUT, 16'(tmo_set[s]));
      write_reg(CFG_LIMIT, 16'(lim_set[s]));
      cfg_valid <= 1'b0;
      tmo_now = tmo_set[s];
      limit_now = lim_set[s];
      // one phase runs with no idling and a long result hold-off
      gaps_on = (s != 3);
      if (s == 3) hold_cycles = 80;
      phase_end = frame_words + quota_set[s];
      if (s == 2) send_frame(FR_GOOD, 16'd400, 0);
      while (frame_words < phase_end) random_frame();
    end

    drain();
    repeat (4) @(posedge clk);
    $display("sent %0d frames (%0d frame words) with ticks and noise under %0d settings",
             frames_sent, frame_words, N_SETTINGS);
    $display("compared %0d result words", words_checked);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sync_length_checksum_deframer_top.f @@
design/sld_pkg.sv
design/sld_parser.sv
design/sync_length_checksum_deframer_top.sv
bench/frame_word_checker.sv
bench/testbench.sv
